### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication checked on every rising clock edge outside reset
`define MCK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define MCK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MCK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// types, constants and code tables shared by the morse keyer modules
// ----------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned MaxElem    = 6;
  localparam int unsigned ElemCntW   = 3;
  localparam int unsigned TailCntW   = 4;
  localparam int unsigned OutDataW   = 8;

  localparam logic [TailCntW-1:0] LetterTail    = 4'd2;
  localparam logic [TailCntW-1:0] SpaceUnits    = 4'd4;
  localparam logic [TailCntW-1:0] LongSpaceUnits = 4'd8;

  localparam logic [CharW-1:0] ChLongSpace = 8'h10;
  localparam logic [CharW-1:0] ChBang      = 8'h21;
  localparam logic [CharW-1:0] ChQuote     = 8'h27;
  localparam logic [CharW-1:0] ChComma     = 8'h2C;
  localparam logic [CharW-1:0] ChPeriod    = 8'h2E;
  localparam logic [CharW-1:0] ChSlash     = 8'h2F;
  localparam logic [CharW-1:0] ChQuestion  = 8'h3F;
  localparam logic [CharW-1:0] ChDigit0    = 8'h30;
  localparam logic [CharW-1:0] ChDigit9    = 8'h39;
  localparam logic [CharW-1:0] ChUpperA    = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ    = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA    = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ    = 8'h7A;

  // one character as elements (first element in bit 0, 1 = dash) plus tail gap
  typedef struct packed {
    logic [ElemCntW-1:0] n_elem;
    logic [MaxElem-1:0]  dash;
    logic [TailCntW-1:0] tail;
  } code_t;

  // element count and dash mask packed as {count, mask}
  typedef logic [ElemCntW+MaxElem-1:0] elem_t;

  function automatic elem_t letter_code(input logic [4:0] idx);
    elem_t r;
    case (idx)
      5'd0:  r = {3'd2, 6'b000010};
      5'd1:  r = {3'd4, 6'b000001};
      5'd2:  r = {3'd4, 6'b000101};
      5'd3:  r = {3'd3, 6'b000001};
      5'd4:  r = {3'd1, 6'b000000};
      5'd5:  r = {3'd4, 6'b000100};
      5'd6:  r = {3'd3, 6'b000011};
      5'd7:  r = {3'd4, 6'b000000};
      5'd8:  r = {3'd2, 6'b000000};
      5'd9:  r = {3'd4, 6'b001110};
      5'd10: r = {3'd3, 6'b000101};
      5'd11: r = {3'd4, 6'b000010};
      5'd12: r = {3'd2, 6'b000011};
      5'd13: r = {3'd2, 6'b000001};
      5'd14: r = {3'd3, 6'b000111};
      5'd15: r = {3'd4, 6'b000110};
      5'd16: r = {3'd4, 6'b001011};
      5'd17: r = {3'd3, 6'b000010};
      5'd18: r = {3'd3, 6'b000000};
      5'd19: r = {3'd1, 6'b000001};
      5'd20: r = {3'd3, 6'b000100};
      5'd21: r = {3'd4, 6'b001000};
      5'd22: r = {3'd3, 6'b000110};
      5'd23: r = {3'd4, 6'b001001};
      5'd24: r = {3'd4, 6'b001101};
      5'd25: r = {3'd4, 6'b000011};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic elem_t digit_code(input logic [3:0] idx);
    elem_t r;
    case (idx)
      4'd0: r = {3'd5, 6'b011111};
      4'd1: r = {3'd5, 6'b011110};
      4'd2: r = {3'd5, 6'b011100};
      4'd3: r = {3'd5, 6'b011000};
      4'd4: r = {3'd5, 6'b010000};
      4'd5: r = {3'd5, 6'b000000};
      4'd6: r = {3'd5, 6'b000001};
      4'd7: r = {3'd5, 6'b000011};
      4'd8: r = {3'd5, 6'b000111};
      4'd9: r = {3'd5, 6'b001111};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/mck_lookup.sv
// ----------------------------------------------------------------------------
// mck_lookup
// classifies a character byte and fetches its element list and tail gap
// ----------------------------------------------------------------------------
`default_nettype none

module mck_lookup (
  input  logic [mck_pkg::CharW-1:0] char_i,
  output mck_pkg::code_t            code_o
);

  logic [4:0]     up_off;
  logic [4:0]     lo_off;
  logic [3:0]     dg_off;
  mck_pkg::elem_t elem;

  assign up_off = 5'(char_i - mck_pkg::ChUpperA);
  assign lo_off = 5'(char_i - mck_pkg::ChLowerA);
  assign dg_off = 4'(char_i - mck_pkg::ChDigit0);

  // letters and digits from tables, punctuation by byte, the rest are gaps
  always_comb begin
    elem        = '0;
    code_o.tail = mck_pkg::LetterTail;
    if (char_i >= mck_pkg::ChUpperA && char_i <= mck_pkg::ChUpperZ) begin
      elem = mck_pkg::letter_code(up_off);
    end else if (char_i >= mck_pkg::ChLowerA && char_i <= mck_pkg::ChLowerZ) begin
      elem = mck_pkg::letter_code(lo_off);
    end else if (char_i >= mck_pkg::ChDigit0 && char_i <= mck_pkg::ChDigit9) begin
      elem = mck_pkg::digit_code(dg_off);
    end else begin
      case (char_i)
        mck_pkg::ChPeriod:   elem = {3'd6, 6'b101010};
        mck_pkg::ChComma:    elem = {3'd6, 6'b110011};
        mck_pkg::ChQuestion: elem = {3'd6, 6'b001100};
        mck_pkg::ChSlash:    elem = {3'd5, 6'b001001};
        mck_pkg::ChQuote:    elem = {3'd6, 6'b011110};
        mck_pkg::ChBang:     elem = {3'd6, 6'b110101};
        mck_pkg::ChLongSpace: begin
          elem        = '0;
          code_o.tail = mck_pkg::LongSpaceUnits;
        end
        default: begin
          elem        = '0;
          code_o.tail = mck_pkg::SpaceUnits;
        end
      endcase
    end
    code_o.n_elem = elem[mck_pkg::ElemCntW+mck_pkg::MaxElem-1:mck_pkg::MaxElem];
    code_o.dash   = elem[mck_pkg::MaxElem-1:0];
  end

endmodule

`default_nettype wire

### design/mck_serializer.sv
// ----------------------------------------------------------------------------
// mck_serializer
// shifts the element list out one element at a time, one key unit per cycle unless the output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module mck_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  mck_pkg::code_t code_i,
  output logic           busy_o,
  output logic           unit_valid_o,
  input  logic           unit_ready_i,
  output logic           key_o,
  output logic           last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ELEM,
    ST_TAIL
  } state_e;

  state_e                        state_q;
  logic [mck_pkg::ElemCntW-1:0]  elem_q;
  logic [mck_pkg::MaxElem-1:0]   dash_q;
  logic [mck_pkg::TailCntW-1:0]  tail_q;
  logic [1:0]                    sub_q;
  logic                          valid_q;
  logic                          key_q;
  logic                          last_q;
  logic                          adv;
  logic [1:0]                    sub_end;

  // output slot frees when empty or taken this cycle
  assign adv     = !valid_q || unit_ready_i;
  // dot is one unit on, dash three on, each followed by one unit off
  assign sub_end = dash_q[0] ? 2'd3 : 2'd1;

  // sequencer with registered output unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      elem_q  <= '0;
      dash_q  <= '0;
      tail_q  <= '0;
      sub_q   <= '0;
      valid_q <= 1'b0;
      key_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (adv) begin
            valid_q <= 1'b0;
          end
          if (load_i) begin
            elem_q  <= code_i.n_elem;
            dash_q  <= code_i.dash;
            tail_q  <= code_i.tail;
            sub_q   <= '0;
            state_q <= (code_i.n_elem == '0) ? ST_TAIL : ST_ELEM;
          end
        end
        ST_ELEM: begin
          if (adv) begin
            valid_q <= 1'b1;
            key_q   <= (sub_q != sub_end);
            last_q  <= 1'b0;
            if (sub_q == sub_end) begin
              sub_q  <= '0;
              dash_q <= dash_q >> 1;
              elem_q <= elem_q - 1'b1;
              if (elem_q == mck_pkg::ElemCntW'(1)) begin
                state_q <= ST_TAIL;
              end
            end else begin
              sub_q <= sub_q + 1'b1;
            end
          end
        end
        ST_TAIL: begin
          if (adv) begin
            valid_q <= 1'b1;
            key_q   <= 1'b0;
            last_q  <= (tail_q == mck_pkg::TailCntW'(1));
            tail_q  <= tail_q - 1'b1;
            if (tail_q == mck_pkg::TailCntW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign unit_valid_o = valid_q;
  assign key_o        = key_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

### design/morse_code_keyer_core.sv
// ----------------------------------------------------------------------------
// morse_code_keyer_core
// turns character bytes into a stream of morse key levels, one per dot unit
// ----------------------------------------------------------------------------
// A character byte is taken when the keyer is idle; it is looked up in the
// morse table (letters of either case, digits, . , ? / ' !; 0x10 is an
// eight-unit gap and any other byte a four-unit gap) and sent out one key
// unit per cycle while the receiver keeps taking them, the final unit of
// the character flagged by m_tlast_o. A character has 4 to 22 units; the
// element sequencer emits at most one unit per clock, and the next byte is
// taken as soon as the sequencer has produced the last unit, even while
// that unit still waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module morse_code_keyer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [mck_pkg::CharW-1:0]    s_tdata_i,   // [7:0] ascii_char
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [mck_pkg::OutDataW-1:0] m_tdata_o,   // [0] key_on, [7:1] zero
  output logic                         m_tlast_o    // last_unit
);

  mck_pkg::code_t code;
  logic           busy;
  logic           load;
  logic           key;

  // input taken only when the sequencer is idle
  assign s_tready_o = !busy;
  assign load       = s_tvalid_i && s_tready_o;

  mck_lookup u_lookup (
    .char_i (s_tdata_i),
    .code_o (code)
  );

  mck_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .code_i       (code),
    .busy_o       (busy),
    .unit_valid_o (m_tvalid_o),
    .unit_ready_i (m_tready_i),
    .key_o        (key),
    .last_o       (m_tlast_o)
  );

  assign m_tdata_o = {{(mck_pkg::OutDataW-1){1'b0}}, key};

  // an accepted item starts the sequencer
  `MCK_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, load, busy)
  // every item has a tail gap, so a flagged last unit always comes
  `MCK_ASSERT_IMPL(a_tail_nonzero, clk_i, rst_ni, load, code.tail != '0)
  // the sequencer goes idle only after emitting the flagged last unit
  `MCK_ASSERT_IMPL(a_idle_after_last, clk_i, rst_ni, $fell(busy), m_tvalid_o && m_tlast_o)

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for morse_code_keyer_core: character bytes go in on the
// slave stream and every key unit coming out is checked against a predicted
// dot/dash expansion, under random idling on both sides and a long stall
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 40;
  localparam logic [7:0]  ChSpace    = 8'h20;

  // one expected key unit
  typedef struct packed {
    logic key_on;
    logic last_unit;
  } key_unit_t;

  // morse expansion of each accepted byte and in-order unit checking
  class keyer_scoreboard;
    key_unit_t units_q[$];
    int unsigned errors;
    int unsigned chars_noted;
    int unsigned units_checked;

    function new();
      errors        = 0;
      chars_noted   = 0;
      units_checked = 0;
    endfunction

    // dots and dashes for one folded character, empty for any gap
    function string pattern_of(logic [7:0] u);
      case (u)
        "A": return ".-";      "B": return "-...";    "C": return "-.-.";
        "D": return "-..";     "E": return ".";       "F": return "..-.";
        "G": return "--.";     "H": return "....";    "I": return "..";
        "J": return ".---";    "K": return "-.-";     "L": return ".-..";
        "M": return "--";      "N": return "-.";      "O": return "---";
        "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
        "S": return "...";     "T": return "-";       "U": return "..-";
        "V": return "...-";    "W": return ".--";     "X": return "-..-";
        "Y": return "-.--";    "Z": return "--..";
        "0": return "-----";   "1": return ".----";   "2": return "..---";
        "3": return "...--";   "4": return "....-";   "5": return ".....";
        "6": return "-....";   "7": return "--...";   "8": return "---..";
        "9": return "----.";
        mck_pkg::ChPeriod:   return ".-.-.-";
        mck_pkg::ChComma:    return "--..--";
        mck_pkg::ChQuestion: return "..--..";
        mck_pkg::ChSlash:    return "-..-.";
        mck_pkg::ChQuote:    return ".----.";
        mck_pkg::ChBang:     return "-.-.--";
        default:             return "";
      endcase
    endfunction

    // expand an accepted byte into its key units
    function void note_char(logic [7:0] c);
      logic [7:0]  folded;
      string       pat;
      logic [31:0] levels;
      int          n;
      key_unit_t   u;
      folded = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      pat    = pattern_of(folded);
      levels = '0;
      n      = 0;
      if (pat.len() == 0) begin
        n = (c == mck_pkg::ChLongSpace) ? 8 : 4;
      end else begin
        for (int i = 0; i < pat.len(); i++) begin
          levels[n] = 1'b1;
          n++;
          if (pat[i] == "-") begin
            levels[n]   = 1'b1;
            levels[n+1] = 1'b1;
            n += 2;
          end
          n++;
        end
        n += 2;
      end
      for (int i = 0; i < n; i++) begin
        u.key_on    = levels[i];
        u.last_unit = (i == n - 1);
        units_q.push_back(u);
      end
      chars_noted++;
    endfunction

    // compare one output unit with the oldest expected one
    function void check_unit(logic [7:0] tdata, logic tlast);
      key_unit_t e;
      if (units_q.size() == 0) begin
        $error("unexpected key unit: tdata %02h tlast %0b", tdata, tlast);
        errors++;
        return;
      end
      e = units_q.pop_front();
      units_checked++;
      if (tdata !== {7'b0, e.key_on}) begin
        $error("key_on mismatch: expected %02h actual %02h", {7'b0, e.key_on}, tdata);
        errors++;
      end
      if (tlast !== e.last_unit) begin
        $error("last_unit mismatch: expected %0b actual %0b", e.last_unit, tlast);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return units_q.size();
    endfunction
  endclass

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       s_tvalid_i = 1'b0;
  logic       s_tready_o;
  logic [7:0] s_tdata_i  = '0;
  logic       m_tvalid_o;
  logic       m_tready_i = 1'b0;
  logic [7:0] m_tdata_o;
  logic       m_tlast_o;

  int unsigned     cycle_cnt     = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  logic            hold_req      = 1'b0;
  keyer_scoreboard sb            = new();

  logic [7:0] directed_chars [24] = '{
    8'h00, 8'hFF, 8'h80, 8'h7F, "A", "z", "e", "T", "0", "9", "5",
    mck_pkg::ChPeriod, mck_pkg::ChComma, mck_pkg::ChQuestion, mck_pkg::ChSlash,
    mck_pkg::ChQuote, mck_pkg::ChBang, mck_pkg::ChLongSpace, ChSpace,
    8'h40, 8'h5B, 8'h60, 8'h7B, "q"
  };

  morse_code_keyer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),   // [7:0] ascii_char
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),   // [0] key_on, [7:1] zero
    .m_tlast_o  (m_tlast_o)    // last_unit
  );

  // clock and cycle count
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random tready, plus one long hold-off when asked
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_tready_i <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      sb.check_unit(m_tdata_o, m_tlast_o);
    end
  end

  // offer one byte, called and returning at a falling edge
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= c;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_char(c);
    @(negedge clk_i);
  endtask

  // mostly table characters, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'(mck_pkg::ChUpperA + $urandom_range(0, 25));
    if (r < 55) return 8'(mck_pkg::ChLowerA + $urandom_range(0, 25));
    if (r < 70) return 8'(mck_pkg::ChDigit0 + $urandom_range(0, 9));
    if (r < 80) begin
      case ($urandom_range(0, 5))
        0:       return mck_pkg::ChPeriod;
        1:       return mck_pkg::ChComma;
        2:       return mck_pkg::ChQuestion;
        3:       return mck_pkg::ChSlash;
        4:       return mck_pkg::ChQuote;
        default: return mck_pkg::ChBang;
      endcase
    end
    if (r < 85) return ChSpace;
    if (r < 88) return mck_pkg::ChLongSpace;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input int n, input int unsigned sp, input int unsigned rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int i = 0; i < n; i++) begin
      send_char(pick_char());
    end
  endtask

  // stimulus
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 53;
    foreach (directed_chars[i]) begin
      send_char(directed_chars[i]);
    end

    run_phase(79, 21, 53);
    run_phase(79, 53, 21);
    // no idling, receiver stalls long once so the input backs up
    hold_req = 1'b1;
    run_phase(78, 0, 0);
    s_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d characters (table entries, both letter cases, gaps, odd bytes)",
             sb.chars_noted);
    $display("checked %0d key units over three idling mixes and one long output stall",
             sb.units_checked);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/mck_pkg.sv
design/mck_lookup.sv
design/mck_serializer.sv
design/morse_code_keyer_core.sv
verif/tb.sv
